// File: rtl/tdtd_pkg.sv
// ----------------------------------------------------------------------------
// tdtd_pkg
// types, field layout and register codes shared by the tap detector files
// ----------------------------------------------------------------------------
package tdtd_pkg;

  // event kinds carried on in_tuser
  localparam logic [1:0] CMD_DOWN = 2'd0;
  localparam logic [1:0] CMD_UP   = 2'd1;

  // register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_TAP_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_TAP_SLOP_SQ  = 2'd1;
  localparam logic [1:0] REG_DTAP_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_DTAP_SLOP_SQ = 2'd3;

  localparam int CMD_W     = 2;
  localparam int IN_DATA_W = 104;
  localparam int OUT_DATA_W = 8;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  // bit offsets inside in_tdata
  localparam int OFS_COUNT = 0;
  localparam int OFS_ID    = 4;
  localparam int OFS_PX    = 8;
  localparam int OFS_PY    = 24;
  localparam int OFS_ETIME = 40;
  localparam int OFS_DTIME = 72;

  // reset values
  localparam logic [31:0] RST_TAP_TIMEOUT  = 32'd180;
  localparam logic [32:0] RST_TAP_SLOP_SQ  = 33'd10240;
  localparam logic [31:0] RST_DTAP_TIMEOUT = 32'd300;
  localparam logic [32:0] RST_DTAP_SLOP_SQ = 33'd160000;
  localparam logic signed [15:0] CLEARED_POS = -16'sd100;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         pointer_count;
    logic [3:0]         pointer_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        event_time;
    logic [31:0]        down_time;
  } event_t;

  typedef struct packed {
    logic [3:0]         down_id;
    logic signed [15:0] down_px;
    logic signed [15:0] down_py;
    logic [31:0]        last_tap_stamp;
    logic signed [15:0] last_tap_px;
    logic signed [15:0] last_tap_py;
  } state_t;

  typedef struct packed {
    logic [31:0] tap_window;
    logic [32:0] tap_slop_sq;
    logic [31:0] dtap_timeout;
    logic [32:0] dtap_slop_sq;
  } cfg_t;

  typedef struct packed {
    logic double_tap_found;
    logic tap_found;
  } result_t;

endpackage

// File: rtl/tdtd_eval.sv
// ----------------------------------------------------------------------------
// tdtd_eval
// judges one touch event against the gesture state and gives the next state
// ----------------------------------------------------------------------------
module tdtd_eval (
  input  tdtd_pkg::event_t  ev,
  input  tdtd_pkg::state_t  st,
  input  tdtd_pkg::cfg_t    cfg,
  output tdtd_pkg::result_t res,
  output tdtd_pkg::state_t  st_nxt
);
  import tdtd_pkg::*;

  logic        single;
  logic        is_down;
  logic        is_up;
  logic [15:0] ref_x;
  logic [15:0] ref_y;
  logic [31:0] ref_t;
  logic [31:0] t_lim;
  logic [32:0] slop;
  logic [31:0] dt;
  logic        time_ok;
  logic [16:0] dx;
  logic [16:0] dy;
  logic [16:0] dx_neg;
  logic [16:0] dy_neg;
  logic [15:0] adx;
  logic [15:0] ady;
  logic [31:0] sqx;
  logic [31:0] sqy;
  logic [32:0] dist_sum;
  logic        near;
  logic        dtap;
  logic        tap;

  assign single  = (ev.pointer_count == 4'd1);
  assign is_down = (ev.cmd == CMD_DOWN);
  assign is_up   = (ev.cmd == CMD_UP);

  // a down is checked against the last tap, an up against the recorded down
  assign ref_x = is_down ? st.last_tap_px    : st.down_px;
  assign ref_y = is_down ? st.last_tap_py    : st.down_py;
  assign ref_t = is_down ? st.last_tap_stamp : ev.down_time;
  assign t_lim = is_down ? cfg.dtap_timeout  : cfg.tap_window;
  assign slop  = is_down ? cfg.dtap_slop_sq  : cfg.tap_slop_sq;

  // wrapping time difference
  assign dt      = ev.event_time - ref_t;
  assign time_ok = (dt <= t_lim);

  assign dx     = {ev.pos_x[15], ev.pos_x} - {ref_x[15], ref_x};
  assign dy     = {ev.pos_y[15], ev.pos_y} - {ref_y[15], ref_y};
  assign dx_neg = 17'd0 - dx;
  assign dy_neg = 17'd0 - dy;
  // magnitude is at most 65535, so 16 bits hold it
  assign adx    = dx[16] ? dx_neg[15:0] : dx[15:0];
  assign ady    = dy[16] ? dy_neg[15:0] : dy[15:0];
  assign sqx    = {16'd0, adx} * {16'd0, adx};
  assign sqy    = {16'd0, ady} * {16'd0, ady};
  assign dist_sum = {1'b0, sqx} + {1'b0, sqy};
  assign near   = (dist_sum < slop);

  assign dtap = single && is_down && time_ok && near;
  assign tap  = single && is_up && time_ok && (ev.pointer_id == st.down_id) && near;

  assign res.tap_found        = tap;
  assign res.double_tap_found = dtap;

  always_comb begin
    st_nxt = st;
    if (single && is_down) begin
      st_nxt.down_id = ev.pointer_id;
      st_nxt.down_px = ev.pos_x;
      st_nxt.down_py = ev.pos_y;
    end
    if (dtap) begin
      st_nxt.last_tap_stamp = 32'd0;
      st_nxt.last_tap_px    = CLEARED_POS;
      st_nxt.last_tap_py    = CLEARED_POS;
    end
    if (tap) begin
      st_nxt.last_tap_stamp = ev.event_time;
      st_nxt.last_tap_px    = ev.pos_x;
      st_nxt.last_tap_py    = ev.pos_y;
    end
  end

endmodule

// File: rtl/tap_and_double_tap_detector.sv
// ----------------------------------------------------------------------------
// tap_and_double_tap_detector
// Single-touch tap and double-tap detector. Each event transfer on the in_
// channel produces exactly one result transfer on the out_ channel carrying
// tap_found and double_tap_found. The block takes one event per clock while
// the result stream is not stalled: each event is held in the input register
// before its result lands in the output register, so the throughput is
// one event per cycle; the limit is the gesture state, which each event reads
// and rewrites as it advances. Events with more than one pointer leave
// the state alone and report nothing. Thresholds live in four registers on
// the APB port (byte addresses 0x00, 0x08, 0x10, 0x18); slop registers are
// squared pixel distances with the screen density already folded in. Change
// them only while no event is in flight.
// ----------------------------------------------------------------------------
module tap_and_double_tap_detector (
  input  logic                               clk,
  input  logic                               rst_n,
  // event stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pointer_count[3:0], pointer_id[7:4], pos_x[23:8], pos_y[39:24],
  // event_time[71:40], down_time[103:72]
  input  logic [tdtd_pkg::IN_DATA_W-1:0]     in_tdata,
  // command[1:0]
  input  logic [tdtd_pkg::CMD_W-1:0]         in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tap_found[0], double_tap_found[1], zero pad[7:2]
  output logic [tdtd_pkg::OUT_DATA_W-1:0]    out_tdata,
  // register port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [tdtd_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  logic [tdtd_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic [tdtd_pkg::APB_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import tdtd_pkg::*;

  // register file
  cfg_t        cfg_r;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  // pipeline
  logic        in_valid_r;
  event_t      in_evt_r;
  event_t      in_evt;
  logic        out_valid_r;
  result_t     out_res_r;
  logic        adv;
  logic        in_fire;

  // gesture state
  state_t      state_r;
  state_t      state_nxt;
  result_t     res_nxt;

  // ---------------- config port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tap_window   <= RST_TAP_TIMEOUT;
      cfg_r.tap_slop_sq  <= RST_TAP_SLOP_SQ;
      cfg_r.dtap_timeout <= RST_DTAP_TIMEOUT;
      cfg_r.dtap_slop_sq <= RST_DTAP_SLOP_SQ;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TAP_TIMEOUT:  cfg_r.tap_window   <= cfg_pwdata[31:0];
        REG_TAP_SLOP_SQ:  cfg_r.tap_slop_sq  <= cfg_pwdata[32:0];
        REG_DTAP_TIMEOUT: cfg_r.dtap_timeout <= cfg_pwdata[31:0];
        REG_DTAP_SLOP_SQ: cfg_r.dtap_slop_sq <= cfg_pwdata[32:0];
        default:          ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (reg_idx)
      REG_TAP_TIMEOUT:  cfg_prdata = {32'd0, cfg_r.tap_window};
      REG_TAP_SLOP_SQ:  cfg_prdata = {31'd0, cfg_r.tap_slop_sq};
      REG_DTAP_TIMEOUT: cfg_prdata = {32'd0, cfg_r.dtap_timeout};
      REG_DTAP_SLOP_SQ: cfg_prdata = {31'd0, cfg_r.dtap_slop_sq};
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------- input unpack ----------------
  always_comb begin
    in_evt.cmd           = in_tuser;
    in_evt.pointer_count = in_tdata[OFS_COUNT +: 4];
    in_evt.pointer_id    = in_tdata[OFS_ID    +: 4];
    in_evt.pos_x         = in_tdata[OFS_PX    +: 16];
    in_evt.pos_y         = in_tdata[OFS_PY    +: 16];
    in_evt.event_time    = in_tdata[OFS_ETIME +: 32];
    in_evt.down_time     = in_tdata[OFS_DTIME +: 32];
  end

  // ---------------- handshake ----------------
  // the held event moves on whenever the result register is free or draining
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_evt_r <= in_evt;
    end
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  // ---------------- decision logic ----------------
  tdtd_eval u_eval (
    .ev     (in_evt_r),
    .st     (state_r),
    .cfg    (cfg_r),
    .res    (res_nxt),
    .st_nxt (state_nxt)
  );

  // state commits together with the result, so the next event sees it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.down_id        <= 4'd0;
      state_r.down_px        <= 16'sd0;
      state_r.down_py        <= 16'sd0;
      state_r.last_tap_stamp <= 32'd0;
      state_r.last_tap_px    <= CLEARED_POS;
      state_r.last_tap_py    <= CLEARED_POS;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.double_tap_found, out_res_r.tap_found};

  // ---------------- assertions ----------------
  // a double tap wipes the last-tap record
  a_dtap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_nxt.double_tap_found |=>
      state_r.last_tap_stamp == 32'd0 && state_r.last_tap_px == CLEARED_POS &&
      state_r.last_tap_py == CLEARED_POS)
    else $error("double tap did not clear last tap record");

  // a tap records the event time of that up
  a_tap_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_nxt.tap_found |=>
      state_r.last_tap_stamp == $past(in_evt_r.event_time))
    else $error("tap did not store its timestamp");

  // multi-pointer events leave the gesture state untouched
  a_multi_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_evt_r.pointer_count > 4'd1 |=>
      $stable(state_r) && !out_res_r.tap_found && !out_res_r.double_tap_found)
    else $error("multi-pointer event changed state or reported");

  // one event never reports both gestures
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.tap_found && out_res_r.double_tap_found))
    else $error("tap and double tap reported together");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tap and double-tap detector. Touch events go in
// on the in_ stream: a directed set first, then random gestures (down and up
// pairs with second downs near the last tap) mixed with noise. A scoreboard
// keeps its own gesture state and thresholds, works out tap_found and
// double_tap_found for every accepted event, and compares each result
// transfer with the oldest expected result. Thresholds are changed over APB
// between phases, defaults, all-ones, all-zeros and random values among them.
// ----------------------------------------------------------------------------

class gesture_checker;
  tdtd_pkg::cfg_t    thresholds;
  tdtd_pkg::state_t  touch;
  tdtd_pkg::result_t expected_gestures[$];
  int                errors;

  function new();
    thresholds.tap_window   = tdtd_pkg::RST_TAP_TIMEOUT;
    thresholds.tap_slop_sq  = tdtd_pkg::RST_TAP_SLOP_SQ;
    thresholds.dtap_timeout = tdtd_pkg::RST_DTAP_TIMEOUT;
    thresholds.dtap_slop_sq = tdtd_pkg::RST_DTAP_SLOP_SQ;
    touch.down_id        = '0;
    touch.down_px        = '0;
    touch.down_py        = '0;
    touch.last_tap_stamp = '0;
    touch.last_tap_px    = tdtd_pkg::CLEARED_POS;
    touch.last_tap_py    = tdtd_pkg::CLEARED_POS;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [63:0] value);
    case (idx)
      tdtd_pkg::REG_TAP_TIMEOUT:  thresholds.tap_window   = value[31:0];
      tdtd_pkg::REG_TAP_SLOP_SQ:  thresholds.tap_slop_sq  = value[32:0];
      tdtd_pkg::REG_DTAP_TIMEOUT: thresholds.dtap_timeout = value[31:0];
      default:                    thresholds.dtap_slop_sq = value[32:0];
    endcase
  endfunction

  function logic [63:0] reg_value(logic [1:0] idx);
    case (idx)
      tdtd_pkg::REG_TAP_TIMEOUT:  return {32'd0, thresholds.tap_window};
      tdtd_pkg::REG_TAP_SLOP_SQ:  return {31'd0, thresholds.tap_slop_sq};
      tdtd_pkg::REG_DTAP_TIMEOUT: return {32'd0, thresholds.dtap_timeout};
      default:                    return {31'd0, thresholds.dtap_slop_sq};
    endcase
  endfunction

  function longint sq_dist(logic signed [15:0] ax, logic signed [15:0] ay,
                           logic signed [15:0] bx, logic signed [15:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy;
  endfunction

  // advance the gesture state by one accepted event
  function void note_event(tdtd_pkg::event_t ev);
    tdtd_pkg::result_t found;
    logic [31:0]       gap;
    found = '0;
    if (ev.pointer_count <= 4'd1) begin
      if (ev.cmd == tdtd_pkg::CMD_DOWN) begin
        if (ev.pointer_count == 4'd1) begin
          touch.down_id = ev.pointer_id;
          touch.down_px = ev.pos_x;
          touch.down_py = ev.pos_y;
          gap = ev.event_time - touch.last_tap_stamp;
          if (gap <= thresholds.dtap_timeout &&
              sq_dist(ev.pos_x, ev.pos_y, touch.last_tap_px, touch.last_tap_py) <
              longint'(thresholds.dtap_slop_sq)) begin
            found.double_tap_found = 1'b1;
            touch.last_tap_stamp   = '0;
            touch.last_tap_px      = tdtd_pkg::CLEARED_POS;
            touch.last_tap_py      = tdtd_pkg::CLEARED_POS;
          end
        end
      end else if (ev.cmd == tdtd_pkg::CMD_UP) begin
        gap = ev.event_time - ev.down_time;
        if (ev.pointer_count == 4'd1 && gap <= thresholds.tap_window &&
            ev.pointer_id == touch.down_id &&
            sq_dist(ev.pos_x, ev.pos_y, touch.down_px, touch.down_py) <
            longint'(thresholds.tap_slop_sq)) begin
          found.tap_found      = 1'b1;
          touch.last_tap_stamp = ev.event_time;
          touch.last_tap_px    = ev.pos_x;
          touch.last_tap_py    = ev.pos_y;
        end
      end
    end
    expected_gestures = {expected_gestures, found};
  endfunction

  function void check_result(logic [7:0] data);
    tdtd_pkg::result_t want;
    if (expected_gestures.size() == 0) begin
      $error("result transfer with no event waiting: tdata %h", data);
      errors++;
      return;
    end
    want = expected_gestures.pop_front();
    if (data[0] !== want.tap_found) begin
      $error("tap_found: expected %0b, actual %0b", want.tap_found, data[0]);
      errors++;
    end
    if (data[1] !== want.double_tap_found) begin
      $error("double_tap_found: expected %0b, actual %0b", want.double_tap_found, data[1]);
      errors++;
    end
  endfunction

  function int outstanding();
    return expected_gestures.size();
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tdtd_pkg::*;

  // codes without a name in the package
  localparam logic [1:0] CMD_OTHER    = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam int LATENCY        = 2;    // input register plus output register
  localparam int HOLD_CYCLES    = 60;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000; // cycles without any transfer

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata;
  logic [CMD_W-1:0]        in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [APB_ADDR_W-1:0]   cfg_paddr;
  logic [APB_DATA_W-1:0]   cfg_pwdata;
  logic [APB_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  gesture_checker gestures = new();

  bit          tx_idle_on  = 1'b1;  // sender may insert gaps
  bit          rx_idle_on  = 1'b1;  // receiver may insert stalls
  bit          rx_hold_req = 1'b0;  // ask the receiver for one long hold-off
  int          items_sent  = 0;
  logic [31:0] stamp_now   = 32'd2000; // running event clock for gestures

  tap_and_double_tap_detector u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // every result transfer is checked against the oldest expected result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      gestures.check_result(out_tdata);
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready  = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (rx_idle_on && rst_n && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      out_tready = rst_n;
    end
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // one event transfer, with an optional gap in front of it
  task automatic send_event(input logic [1:0] cmd, input logic [3:0] count,
                            input logic [3:0] id, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic [31:0] t_evt,
                            input logic [31:0] t_down);
    event_t ev;
    ev.cmd           = cmd;
    ev.pointer_count = count;
    ev.pointer_id    = id;
    ev.pos_x         = x;
    ev.pos_y         = y;
    ev.event_time    = t_evt;
    ev.down_time     = t_down;
    @(negedge clk);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = ev.cmd;
    in_tdata  = {ev.down_time, ev.event_time, ev.pos_y, ev.pos_x,
                 ev.pointer_id, ev.pointer_count};
    do @(posedge clk); while (in_tready !== 1'b1);
    gestures.note_event(ev);
    items_sent++;
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (gestures.outstanding() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
  endtask

  // apb write followed by a read back of the same register
  task automatic apb_write_reg(input logic [1:0] idx, input logic [63:0] value);
    logic [63:0] rd;
    logic [63:0] mask;
    mask = (idx == REG_TAP_SLOP_SQ || idx == REG_DTAP_SLOP_SQ) ?
           64'h1_FFFF_FFFF : 64'hFFFF_FFFF;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 3'b000};
    cfg_pwdata  = value & mask;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    gestures.set_reg(idx, value & mask);
    // read back
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if ((rd & mask) !== gestures.reg_value(idx)) begin
      $error("register %0d: expected %h, actual %h", idx, gestures.reg_value(idx), rd & mask);
      gestures.errors++;
    end
  endtask

  task automatic load_thresholds(input logic [31:0] tap_to, input logic [32:0] tap_slop,
                                 input logic [31:0] dtap_to, input logic [32:0] dtap_slop);
    apb_write_reg(REG_TAP_TIMEOUT,  {32'd0, tap_to});
    apb_write_reg(REG_TAP_SLOP_SQ,  {31'd0, tap_slop});
    apb_write_reg(REG_DTAP_TIMEOUT, {32'd0, dtap_to});
    apb_write_reg(REG_DTAP_SLOP_SQ, {31'd0, dtap_slop});
  endtask

  // delay around a timeout: on it, just past it, just short of it, or small
  function automatic logic [31:0] pick_delay(input logic [31:0] limit);
    case ($urandom_range(0, 5))
      0:       return limit;
      1:       return limit + 32'd1;
      2:       return limit - 32'd1;
      default: return 32'($urandom_range(0, 400));
    endcase
  endfunction

  function automatic int near(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly a single pointer, sometimes none or several
  function automatic logic [3:0] pick_count();
    return ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15)) : 4'd1;
  endfunction

  task automatic send_noise();
    send_event(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 4'($urandom),
               16'($urandom), 16'($urandom), $urandom, $urandom);
  endtask

  // down then up; the down often lands near the last tap
  task automatic send_gesture();
    logic [3:0]         id;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        t_down;
    logic [31:0]        t_up;
    if ($urandom_range(0, 24) == 0) begin
      stamp_now = $urandom;
    end
    if ($urandom_range(0, 1) == 0) begin
      x      = 16'(int'(gestures.touch.last_tap_px) + near(450));
      y      = 16'(int'(gestures.touch.last_tap_py) + near(450));
      t_down = gestures.touch.last_tap_stamp + pick_delay(gestures.thresholds.dtap_timeout);
    end else begin
      x      = 16'($urandom);
      y      = 16'($urandom);
      t_down = stamp_now + 32'($urandom_range(0, 1000));
    end
    id = 4'($urandom);
    send_event(CMD_DOWN, pick_count(), id, x, y, t_down, t_down);
    if ($urandom_range(0, 7) == 0) begin
      send_noise();
    end
    t_up = t_down + pick_delay(gestures.thresholds.tap_window);
    send_event(CMD_UP, pick_count(), ($urandom_range(0, 9) == 0) ? id + 4'd1 : id,
               16'(int'(x) + near(130)), 16'(int'(y) + near(130)), t_up, t_down);
    stamp_now = t_up;
  endtask

  task automatic run_random(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) < 7) begin
        send_gesture();
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin : main
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part on reset thresholds
    // a down near the reset tap position counts as a double tap
    send_event(CMD_DOWN, 4'd1, 4'd3, -16'sd100, -16'sd100, 32'd50, 32'd50);
    send_event(CMD_UP, 4'd1, 4'd3, -16'sd100, -16'sd100, 32'd100, 32'd50);
    // second down exactly at the double-tap timeout
    send_event(CMD_DOWN, 4'd1, 4'd3, -16'sd90, -16'sd95, 32'd400, 32'd400);
    // up exactly at the tap timeout, just inside the slop
    send_event(CMD_UP, 4'd1, 4'd3, 16'sd6, -16'sd64, 32'd580, 32'd400);
    // down exactly at the double-tap slop: no double tap
    send_event(CMD_DOWN, 4'd1, 4'd5, 16'sd406, -16'sd64, 32'd700, 32'd700);
    // one past the tap timeout, then exactly on the tap slop
    send_event(CMD_UP, 4'd1, 4'd5, 16'sd406, -16'sd64, 32'd881, 32'd700);
    send_event(CMD_UP, 4'd1, 4'd5, 16'sd502, -16'sd32, 32'd880, 32'd700);
    // other pointer id
    send_event(CMD_UP, 4'd1, 4'd6, 16'sd406, -16'sd64, 32'd800, 32'd700);
    send_event(CMD_UP, 4'd1, 4'd5, 16'sd406, -16'sd64, 32'd880, 32'd700);
    // no pointer data: nothing recorded, no tap
    send_event(CMD_DOWN, 4'd0, 4'd9, 16'sd406, -16'sd64, 32'd900, 32'd900);
    send_event(CMD_UP, 4'd0, 4'd9, 16'sd406, -16'sd64, 32'd901, 32'd900);
    // several pointers are ignored
    send_event(CMD_DOWN, 4'd2, 4'd5, 16'sd406, -16'sd64, 32'd910, 32'd910);
    send_event(CMD_UP, 4'd15, 4'd5, 16'sd406, -16'sd64, 32'd911, 32'd910);
    // other action and the unused command code
    send_event(CMD_OTHER, 4'd1, 4'd5, 16'sd406, -16'sd64, 32'd912, 32'd910);
    send_event(CMD_RESERVED, 4'd1, 4'd5, 16'sd406, -16'sd64, 32'd913, 32'd910);
    // the last tap survived all of the above
    send_event(CMD_DOWN, 4'd1, 4'd5, 16'sd400, -16'sd60, 32'd1180, 32'd1180);
    // coordinate extremes and a wrapping time difference
    send_event(CMD_DOWN, 4'd1, 4'd15, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFF0, 32'hFFFF_FFF0);
    send_event(CMD_UP, 4'd1, 4'd15, -16'sh8000, -16'sh8000, 32'h0000_0010, 32'hFFFF_FFF0);
    send_event(CMD_UP, 4'd1, 4'd15, 16'sh7FFF, 16'sh7FFF, 32'h0000_0010, 32'hFFFF_FFF0);
    send_event(CMD_DOWN, 4'd1, 4'd0, -16'sh8000, -16'sh8000, 32'h0000_0020, 32'h0000_0020);
    send_event(CMD_DOWN, 4'd1, 4'd0, 16'sh7FFF, 16'sh7FFF, 32'h0000_0030, 32'h0000_0030);

    // random gestures on reset thresholds, with the long hold-off and a pause
    run_random(50);
    rx_hold_req = 1'b1;
    run_random(40);
    wait_drained();
    run_random(60);

    // every threshold at its top value
    wait_drained();
    load_thresholds(32'hFFFF_FFFF, 33'h1_FFFF_FFFF, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
    run_random(80);

    // every threshold at zero: nothing can be a tap
    wait_drained();
    load_thresholds(32'd0, 33'd0, 32'd0, 33'd0);
    run_random(60);

    // random mid-range thresholds
    wait_drained();
    load_thresholds(32'($urandom_range(50, 500)), 33'($urandom_range(0, 40000)),
                    32'($urandom_range(50, 800)), 33'($urandom_range(0, 400000)));
    run_random(100);

    // back to the reset values, full speed on both sides
    wait_drained();
    load_thresholds(RST_TAP_TIMEOUT, RST_TAP_SLOP_SQ, RST_DTAP_TIMEOUT, RST_DTAP_SLOP_SQ);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(150);

    wait_drained();
    if (gestures.errors == 0 && gestures.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: tap_and_double_tap_detector.f
rtl/tdtd_pkg.sv
rtl/tdtd_eval.sv
rtl/tap_and_double_tap_detector.sv
tb/testbench.sv
